@@ rtl/line_filter_with_context_top_assert.svh @@
// Assertion macros for the line filter checker.
`ifndef LINE_FILTER_WITH_CONTEXT_TOP_ASSERT_SVH
`define LINE_FILTER_WITH_CONTEXT_TOP_ASSERT_SVH
// Implication checked on every clock, off during reset.
`define LFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define LFC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/lfc_pkg.sv @@
// Package: types and constants for the line filter.
package lfc_pkg;
    localparam int PATTERN_MAX = 128;
    localparam int MAX_CONTEXT = 63;
    localparam int PAT_W = 8;
    localparam logic [1:0] REQ_TEXT = 2'd0;
    localparam logic [1:0] REQ_LOAD = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;
    localparam logic [1:0] CFG_PLEN = 2'd0;
    localparam logic [1:0] CFG_CTX  = 2'd1;
    localparam logic [1:0] CFG_MODE = 2'd2;
    localparam logic [1:0] CFG_CNT  = 2'd3;
    localparam logic [1:0] MODE_BEFORE = 2'd0;
    localparam logic [1:0] MODE_AFTER  = 2'd1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_value;
        logic [6:0] pattern_index;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] line_index;
        logic [16:0] match_count;
        logic        last;
    } out_item_t;

    // Control broadcast along the cell row.
    typedef struct packed {
        logic       shift;
        logic       clear;
        logic       load;
        logic [6:0] load_idx;
        logic [7:0] ch;
        logic [7:0] plen;
    } cell_ctl_t;
endpackage

@@ rtl/lfc_cell.sv @@
// One comparison cell: holds one pattern byte and a partial-match flag.
module lfc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lfc_pkg::cell_ctl_t  ctl,
    input  logic [7:0]          pos,
    input  logic                prev_match,
    output logic                match
);
    import lfc_pkg::*;

    logic [7:0] pat_reg;
    logic       match_reg;
    logic       match_next;

    // Flag at cell k: the last k+1 chars equal pattern[0..k].
    always_comb
    begin
        match_next = match_reg;
        if (ctl.clear)
            match_next = 1'b0;
        else if (ctl.shift)
            match_next = prev_match && (pat_reg == ctl.ch) && (pos < ctl.plen);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.load_idx == pos[6:0])
            pat_reg <= ctl.ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign match = match_reg;
endmodule

@@ rtl/lfc_ctl.sv @@
// Line bookkeeping and result sequencing.
module lfc_ctl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lfc_pkg::in_item_t   in_data,
    input  logic                hit,
    input  logic [7:0]          plen,
    input  logic [5:0]          ctx_raw,
    input  logic [1:0]          mode,
    input  logic                cnt_en,
    output lfc_pkg::cell_ctl_t  ctl,
    output logic                out_valid,
    input  logic                out_ready,
    output lfc_pkg::out_item_t  out_data
);
    import lfc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EOL, S_EMIT} state_t;

    state_t      state_reg, state_next;
    logic        lhm_reg, lhm_next;
    logic [15:0] cur_reg, cur_next;
    logic [16:0] nup_reg, nup_next;
    logic [5:0]  pend_reg, pend_next;
    logic [16:0] mcnt_reg, mcnt_next;
    logic [16:0] j_reg, j_next;
    logic        ov_reg, ov_next;
    out_item_t   od_reg, od_next;
    logic        acc, match_now;
    logic [16:0] start;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign acc = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_data = od_reg;

    always_comb
    begin
        ctl.shift    = acc && in_data.req_type == REQ_TEXT;
        // Line end wipes the partial matches so none spans two lines.
        ctl.clear    = (acc && in_data.req_type == REQ_END) || state_reg == S_EOL;
        ctl.load     = acc && in_data.req_type == REQ_LOAD;
        ctl.load_idx = in_data.pattern_index;
        ctl.ch       = in_data.char_value;
        ctl.plen     = plen;
    end

    always_comb
    begin
        state_next = state_reg;
        lhm_next   = lhm_reg;
        cur_next   = cur_reg;
        nup_next   = nup_reg;
        pend_next  = pend_reg;
        mcnt_next  = mcnt_reg;
        j_next     = j_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        match_now  = lhm_reg || plen == 8'd0;
        start      = ({1'b0, cur_reg} >= {11'd0, ctx_raw})
                   ? ({1'b0, cur_reg} - {11'd0, ctx_raw}) : 17'd0;
        if (start < nup_reg)
            start = nup_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (in_data.req_type)
                        REQ_TEXT:
                            if (in_data.end_of_line)
                                state_next = S_EOL;
                        REQ_END:
                        begin
                            if (cnt_en)
                            begin
                                ov_next = 1'b1;
                                od_next = '{1'b1, 16'd0, mcnt_reg, 1'b1};
                            end
                            lhm_next = 1'b0; cur_next = '0; nup_next = '0;
                            pend_next = '0; mcnt_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_EOL:
            begin
                // Cell row has taken the final char; its hit is now valid.
                match_now = lhm_reg || hit || plen == 8'd0;
                if (match_now && mcnt_reg != 17'h10000)
                    mcnt_next = mcnt_reg + 17'd1;
                state_next = S_IDLE;
                lhm_next = 1'b0;
                if (ctx_raw == 6'd0)
                begin
                    if (match_now && {1'b0, cur_reg} >= nup_reg)
                    begin
                        ov_next = 1'b1;
                        od_next = '{1'b0, cur_reg, 17'd0, 1'b1};
                        nup_next = {1'b0, cur_reg} + 17'd1;
                    end
                end
                else if (mode == MODE_BEFORE)
                begin
                    // Saturated line counter may leave nothing new to print.
                    if (match_now && start <= {1'b0, cur_reg})
                    begin
                        j_next = start;
                        state_next = S_EMIT;
                    end
                end
                else if (mode == MODE_AFTER)
                begin
                    if (match_now || pend_reg != 6'd0)
                    begin
                        pend_next = match_now ? ctx_raw : pend_reg - 6'd1;
                        if ({1'b0, cur_reg} >= nup_reg)
                        begin
                            ov_next = 1'b1;
                            od_next = '{1'b0, cur_reg, 17'd0, 1'b1};
                            nup_next = {1'b0, cur_reg} + 17'd1;
                        end
                    end
                end
                if (state_next == S_IDLE && cur_reg != 16'hFFFF)
                    cur_next = cur_reg + 16'd1;
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    od_next = '{1'b0, j_reg[15:0], 17'd0, j_reg == {1'b0, cur_reg}};
                    nup_next = j_reg + 17'd1;
                    j_next = j_reg + 17'd1;
                    if (j_reg == {1'b0, cur_reg})
                    begin
                        state_next = S_IDLE;
                        if (cur_reg != 16'hFFFF)
                            cur_next = cur_reg + 16'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        // Previous char's hit folds into the line flag when the next char enters.
        if (state_reg == S_IDLE && acc && in_data.req_type == REQ_TEXT && hit)
            lhm_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lhm_reg   <= 1'b0;
            cur_reg   <= '0;
            nup_reg   <= '0;
            pend_reg  <= '0;
            mcnt_reg  <= '0;
            j_reg     <= '0;
            ov_reg    <= 1'b0;
            od_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lhm_reg   <= lhm_next;
            cur_reg   <= cur_next;
            nup_reg   <= nup_next;
            pend_reg  <= pend_next;
            mcnt_reg  <= mcnt_next;
            j_reg     <= j_next;
            ov_reg    <= ov_next;
            od_reg    <= od_next;
        end
    end
endmodule

@@ rtl/line_filter_with_context_top.sv @@
// Top level: grep-style line filter with context lines.
// A line-end result is registered in state S_EOL, in before mode in S_EMIT; an
// end-of-text count as its beat is taken. Input waits while a result is held.
// Throughput: 1 beat per cycle for mid-line chars and loads while no result is
// held; a line end runs S_EOL, in before mode then S_EMIT per line (up to 64).
// Reset: async active low; registers to reset values, pattern store undefined.
module line_filter_with_context_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lfc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lfc_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import lfc_pkg::*;

    logic [7:0] plen_reg;
    logic [5:0] ctx_reg;
    logic [1:0] mode_reg;
    logic       cnt_reg;
    logic [7:0] plen_eff;
    logic [5:0] ctx_eff;
    logic [1:0] mode_eff;
    cell_ctl_t  ctl;
    logic [PATTERN_MAX:0] chain;
    logic       hit;

    assign cfg_ready = 1'b1;

    // Out-of-range config values clamp: length to PATTERN_MAX, context to MAX_CONTEXT.
    assign plen_eff = (plen_reg > 8'(PATTERN_MAX)) ? 8'(PATTERN_MAX) : plen_reg;
    assign ctx_eff  = (ctx_reg > 6'(MAX_CONTEXT)) ? 6'(MAX_CONTEXT) : ctx_reg;
    assign mode_eff = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            ctx_reg  <= '0;
            mode_reg <= 2'd2;
            cnt_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PLEN: plen_reg <= cfg_data;
                CFG_CTX:  ctx_reg  <= cfg_data[5:0];
                CFG_MODE: mode_reg <= cfg_data[1:0];
                CFG_CNT:  cnt_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Cell k matches when the last k+1 chars equal pattern[0..k]; chain[0] is
    // the always-true seed. A full hit is the flag of cell plen-1.
    assign chain[0] = 1'b1;
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            lfc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .pos        (8'(k)),
                .prev_match (chain[k]),
                .match      (chain[k+1])
            );
        end
    endgenerate

    assign hit = (plen_eff != 8'd0) && chain[plen_eff];

    lfc_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .hit       (hit),
        .plen      (plen_eff),
        .ctx_raw   (ctx_eff),
        .mode      (mode_eff),
        .cnt_en    (cnt_reg),
        .ctl       (ctl),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule

@@ rtl/lfc_checker.sv @@
// Port-level checker for the line filter, bound to the top level.
module lfc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  lfc_pkg::out_item_t out_data
);
    import lfc_pkg::*;
`include "line_filter_with_context_top_assert.svh"

    `LFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `LFC_ASSERT_IMP(a_count_last, out_valid && out_data.result_kind, out_data.last)
    `LFC_ASSERT_IMP(a_count_noline, out_valid && out_data.result_kind, out_data.line_index == 16'd0)
    `LFC_ASSERT_IMP(a_no_in_while_out, in_ready, !out_valid)
endmodule

bind line_filter_with_context_top lfc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ sim/line_filter_with_context_checker.sv @@
// Checker for the line filter: watches all channels, predicts results, compares.
`timescale 1ns / 1ps

module line_filter_with_context_checker
    import lfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int        errors,
    output int        pending
);
    localparam int unsigned LINE_CAP   = 65536;
    localparam logic        KIND_LINE  = 1'b0;
    localparam logic        KIND_COUNT = 1'b1;

    // Shadow registers
    logic [7:0] plen_q;
    logic [5:0] ctx_q;
    logic [1:0] mode_q;
    logic       cnt_q;

    // Shadow text state
    logic [7:0]  pat_mem [PATTERN_MAX];
    logic [7:0]  recent [PATTERN_MAX];
    int unsigned line_chars;
    bit          line_hit;
    int unsigned cur_line;
    int unsigned next_free;
    int unsigned after_left;
    int unsigned hit_lines;

    out_item_t line_burst [$];
    out_item_t printed_lines [$];

    initial errors = 0;

    task automatic clear_text();
        foreach (recent[k]) recent[k] = '0;
        line_chars = 0;
        line_hit   = 0;
        cur_line   = 0;
        next_free  = 0;
        after_left = 0;
        hit_lines  = 0;
    endtask

    function automatic int unsigned pat_len();
        return (plen_q > PATTERN_MAX) ? PATTERN_MAX : plen_q;
    endfunction

    task automatic print_line(input int unsigned l);
        out_item_t r;
        r = '0;
        r.result_kind = KIND_LINE;
        r.line_index  = l[15:0];
        line_burst.push_back(r);
        if (l + 1 > next_free)
            next_free = l + 1;
    endtask

    task automatic absorb_char(input logic [7:0] ch);
        int unsigned len;
        bit same;
        len = pat_len();
        for (int k = PATTERN_MAX - 1; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = ch;
        if (line_chars < 255)
            line_chars++;
        if (len > 0 && line_chars >= len) begin
            same = 1;
            for (int k = 0; k < len; k++)
                if (recent[k] !== pat_mem[len-1-k])
                    same = 0;
            if (same)
                line_hit = 1;
        end
    endtask

    task automatic close_line();
        int unsigned ctx;
        int unsigned j;
        bit hit;
        bit want;
        ctx  = ctx_q;
        hit  = line_hit || pat_len() == 0;
        want = 0;
        line_burst.delete();
        if (hit && hit_lines < LINE_CAP)
            hit_lines++;
        if (ctx == 0) begin
            if (hit && cur_line >= next_free)
                print_line(cur_line);
        end else if (mode_q == MODE_BEFORE) begin
            if (hit) begin
                j = (cur_line >= ctx) ? cur_line - ctx : 0;
                if (j < next_free)
                    j = next_free;
                for (; j <= cur_line; j++)
                    print_line(j);
            end
        end else if (mode_q == MODE_AFTER) begin
            if (hit) begin
                after_left = ctx;
                want = 1;
            end else if (after_left > 0) begin
                after_left--;
                want = 1;
            end
            if (want && cur_line >= next_free)
                print_line(cur_line);
        end
        if (cur_line < LINE_CAP - 1)
            cur_line++;
        line_chars = 0;
        line_hit   = 0;
        if (line_burst.size() > 0)
            line_burst[line_burst.size()-1].last = 1'b1;
        foreach (line_burst[k])
            printed_lines.push_back(line_burst[k]);
    endtask

    task automatic take_beat(input in_item_t b);
        out_item_t r;
        case (b.req_type)
            REQ_TEXT:
            begin
                absorb_char(b.char_value);
                if (b.end_of_line)
                    close_line();
            end
            REQ_LOAD:
                pat_mem[b.pattern_index] = b.char_value;
            REQ_END:
            begin
                if (cnt_q) begin
                    r = '0;
                    r.result_kind = KIND_COUNT;
                    r.match_count = hit_lines[16:0];
                    r.last        = 1'b1;
                    printed_lines.push_back(r);
                end
                clear_text();
            end
            default: ;  // unused request: no effect
        endcase
    endtask

    task automatic check_beat(input out_item_t got);
        out_item_t want;
        if (printed_lines.size() == 0) begin
            $error("unexpected result beat: kind %0d line %0d count %0d",
                   got.result_kind, got.line_index, got.match_count);
            errors++;
            return;
        end
        want = printed_lines.pop_front();
        if (got.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
            errors++;
        end
        if (got.line_index !== want.line_index) begin
            $error("line_index: expected %0d, got %0d", want.line_index, got.line_index);
            errors++;
        end
        if (got.match_count !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            plen_q = '0;
            ctx_q  = '0;
            mode_q = 2'd2;
            cnt_q  = 1'b0;
            foreach (pat_mem[k]) pat_mem[k] = '0;
            clear_text();
            printed_lines.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PLEN: plen_q = cfg_data;
                    CFG_CTX:  ctx_q  = cfg_data[5:0];
                    CFG_MODE: mode_q = cfg_data[1:0];
                    CFG_CNT:  cnt_q  = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                take_beat(in_data);
            if (out_valid && out_ready)
                check_beat(out_data);
        end
        pending = printed_lines.size();
    end

endmodule

@@ sim/line_filter_with_context_top_tb.sv @@
// Testbench top for the line filter: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module line_filter_with_context_top_tb;
    import lfc_pkg::*;

    // Request and mode codes the package leaves unnamed
    localparam logic [1:0] REQ_NONE   = 2'd3;
    localparam logic [1:0] MODE_QUIET = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    // A line end with no result can keep the block busy in S_EOL;
    // before-mode bursts run up to 64 beats, so this tail covers both.
    localparam int DRAIN_TAIL   = 80;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_BEATS = 110;
    localparam int HOLD_LINES   = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    int errors;
    int pending;

    // Pacing controls shared by sender and receiver
    bit quiet = 0;        // no gaps on either side
    bit hold_long = 0;    // receiver holds off for a long stretch once
    int beats_sent = 0;

    // Current pattern, as loaded at indices 0 and up
    logic [7:0] pattern [$];

    line_filter_with_context_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_filter_with_context_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: random hold-off before each result beat, one long hold on request.
    // Every path assigns out_ready at most once per edge.
    initial
    begin
        int gap;
        repeat (10) @(posedge clk);
        forever begin
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 0;
            end
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // One input beat; valid stays up when the next beat follows with no gap
    task automatic send_beat(input logic [1:0] req, input logic [7:0] ch,
                             input logic [6:0] idx, input logic eol);
        int gap;
        in_item_t b;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        b.req_type      = req;
        b.char_value    = ch;
        b.pattern_index = idx;
        b.end_of_line   = eol;
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'("a" + $urandom_range(0, 1));
    endfunction

    task automatic text_char(input logic [7:0] ch, input logic eol);
        send_beat(REQ_TEXT, ch, 7'($urandom_range(0, 127)), eol);
    endtask

    // Sender pause: lower valid, let every expected result drain, then the tail
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // All four registers, only while the block is idle
    task automatic configure(input logic [7:0] plen, input logic [5:0] ctx,
                             input logic [1:0] mode, input logic cnt);
        logic [7:0] vals [4];
        vals[CFG_PLEN] = plen;
        vals[CFG_CTX]  = {2'b00, ctx};
        vals[CFG_MODE] = {6'd0, mode};
        vals[CFG_CNT]  = {7'd0, cnt};
        drain();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic load_pattern(input int len);
        logic [7:0] ch;
        pattern.delete();
        for (int i = 0; i < len; i++) begin
            ch = pick_char();
            pattern.push_back(ch);
            send_beat(REQ_LOAD, ch, 7'(i), 1'($urandom_range(0, 1)));
        end
    endtask

    // Random line, sometimes with the pattern planted in it
    task automatic random_line(input int len, input int plen);
        logic [7:0] chars [$];
        int at;
        for (int i = 0; i < len; i++)
            chars.push_back(pick_char());
        if (plen > 0 && plen <= len && $urandom_range(0, 2) == 0) begin
            at = $urandom_range(0, len - plen);
            for (int i = 0; i < plen; i++)
                chars[at+i] = pattern[i];
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(REQ_NONE, pick_char(), 7'($urandom_range(0, 127)), 1'b1);
            text_char(chars[i], i == len - 1);
        end
    endtask

    initial
    begin
        int plen;
        int target;
        logic [7:0] plen_reg;
        logic [5:0] ctx;
        bit open_line;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty pattern matches every line, no count
        text_char("a", 1'b1);
        text_char(8'hFF, 1'b1);
        send_beat(REQ_NONE, 8'h00, 7'h7F, 1'b1);
        text_char(8'h00, 1'b0);            // unfinished line, dropped at end
        send_beat(REQ_END, 8'hFF, 7'h00, 1'b0);

        // Before mode: a match on line 0 must print line 0
        send_beat(REQ_LOAD, "a", 7'd0, 1'b0);
        send_beat(REQ_LOAD, "b", 7'd1, 1'b1);
        pattern = '{"a", "b"};
        configure(8'd2, 6'd2, MODE_BEFORE, 1'b1);
        text_char("a", 1'b0);
        text_char("b", 1'b1);
        repeat (3) text_char("x", 1'b1);
        text_char("x", 1'b0);
        text_char("a", 1'b0);
        text_char("b", 1'b1);
        send_beat(REQ_END, 8'h00, 7'h00, 1'b0);

        // After mode at the widest context; the trailing lines run past the text end
        configure(8'd2, 6'd63, MODE_AFTER, 1'b1);
        text_char("a", 1'b0);
        text_char("b", 1'b1);
        text_char("z", 1'b1);
        send_beat(REQ_END, 8'h00, 7'h00, 1'b0);

        // Unused mode and print-nothing mode with nonzero context
        configure(8'd1, 6'd5, MODE_SPARE, 1'b1);
        text_char("a", 1'b1);
        configure(8'd1, 6'd5, MODE_QUIET, 1'b0);
        text_char("a", 1'b1);
        send_beat(REQ_END, 8'h00, 7'h00, 1'b0);

        // Receiver holds off while before-mode lines pile up behind it
        configure(8'd0, 6'd63, MODE_BEFORE, 1'b0);
        hold_long = 1;
        for (int i = 0; i < HOLD_LINES; i++)
            text_char(pick_char(), 1'b1);
        send_beat(REQ_END, 8'h00, 7'h00, 1'b0);

        // Random phases with random settings
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            plen = $urandom_range(0, 4);
            case ($urandom_range(0, 3))
                0: ctx = 6'd0;
                1: ctx = 6'd63;
                default: ctx = 6'($urandom_range(1, 6));
            endcase
            drain();
            load_pattern(plen);
            plen_reg = 8'(plen);
            configure(plen_reg, ctx, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(3, 8))
                random_line($urandom_range(1, 10), plen);
            open_line = ($urandom_range(0, 2) == 0);
            if (open_line)
                text_char(pick_char(), 1'b0);      // left unfinished
            // A new pattern never arrives inside a line, so an open line ends the text
            if (open_line || $urandom_range(0, 3) != 0)
                send_beat(REQ_END, pick_char(), 7'($urandom_range(0, 127)), 1'b0);
        end
        send_beat(REQ_END, 8'h00, 7'h00, 1'b0);

        // Final drain, then the verdict
        drain();
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
